[hdl/obstacle_detour_sequencer_unit_assert.svh]
// Assertion macros for the obstacle detour sequencer.
`ifndef OBSTACLE_DETOUR_SEQUENCER_UNIT_ASSERT_SVH
`define OBSTACLE_DETOUR_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define ODS_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ods: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define ODS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ods: next-cycle check failed");

`endif

[hdl/ods_pkg.sv]
// Shared constants for the obstacle detour sequencer.
package ods_pkg;

    localparam int PHASE_W = 4;
    localparam int SPD_W   = 9;
    localparam int RANGE_W = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    // (255 + 255) * 65535 fits 25 bits; after dropping the Q8.8 fraction 17 remain
    localparam int PROD_W = 25;
    localparam int LEN_W  = 17;

    typedef logic [PHASE_W-1:0] t_phase;
    typedef logic signed [SPD_W-1:0] t_speed;

    localparam t_phase P_IDLE        = 4'd0;
    localparam t_phase P_TURN_L1     = 4'd1;
    localparam t_phase P_DRIVE_CLEAR = 4'd2;
    localparam t_phase P_TURN_R1     = 4'd3;
    localparam t_phase P_DRIVE_PASS  = 4'd4;
    localparam t_phase P_TURN_R2     = 4'd5;
    localparam t_phase P_DRIVE_BACK  = 4'd6;
    localparam t_phase P_TURN_L2     = 4'd7;
    localparam t_phase P_REACQUIRE   = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBSTACLE_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLEARANCE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_MS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MS_PER_CM_Q8   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_SPEED     = 3'd6;

    localparam logic [9:0]  RST_NEAR_THRESHOLD = 10'd20;
    localparam logic [7:0]  RST_OBSTACLE_WIDTH = 8'd20;
    localparam logic [7:0]  RST_CLEARANCE      = 8'd5;
    localparam logic [15:0] RST_TURN_MS        = 16'd600;
    localparam logic [15:0] RST_MS_PER_CM_Q8   = 16'd5120;  // 20.0 ms/cm
    localparam logic [7:0]  RST_DRIVE_SPEED    = 8'd140;
    localparam logic [7:0]  RST_TURN_SPEED     = 8'd120;

endpackage

[hdl/ods_in_if.sv]
// Update channel: clock sample, line flag and range sample.
interface ods_in_if #(
    parameter int TIME_WIDTH = 32
);
    logic                             valid;
    logic                             ready;
    logic [TIME_WIDTH-1:0]            now_ms;
    logic                             on_line;
    logic [ods_pkg::RANGE_W-1:0]      range_cm;

    modport source (output valid, output now_ms, output on_line, output range_cm, input ready);
    modport sink   (input valid, input now_ms, input on_line, input range_cm, output ready);
endinterface

[hdl/ods_out_if.sv]
// Result channel: motor command, phase and obstacle flag.
interface ods_out_if;
    logic                  valid;
    logic                  ready;
    logic                  motor_write;
    ods_pkg::t_speed       left_speed;
    ods_pkg::t_speed       right_speed;
    ods_pkg::t_phase       phase_now;
    logic                  obstacle_near;

    modport source (output valid, output motor_write, output left_speed, output right_speed,
                    output phase_now, output obstacle_near, input ready);
    modport sink   (input valid, input motor_write, input left_speed, input right_speed,
                    input phase_now, input obstacle_near, output ready);
endinterface

[hdl/obstacle_detour_sequencer_unit.sv]
// Obstacle detour sequencer: nine-phase turn/drive sequence with motor command output.
//
//   channel   dir   handshake         payload
//   in_ch     in    valid / ready     now_ms, on_line, range_cm
//   out_ch    out   valid / ready     motor_write, left/right_speed, phase_now, obstacle_near
//   cfg       in    i_cfg_we          i_cfg_idx, i_cfg_data
//
// One item per cycle unless out_ch stalls; results appear the cycle after items are taken.
// Phase logic, leg-length multiply (9x16) and elapsed-time compare sit between the
// phase registers and the result register.
// Input ready is high while the result register is empty or being drained.
// Synchronous active-low reset restores the register defaults and the idle phase.
`include "obstacle_detour_sequencer_unit_assert.svh"

module obstacle_detour_sequencer_unit #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ods_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ods_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    ods_in_if.sink                          in_ch,
    ods_out_if.source                       out_ch
);

    localparam int CMP_W = (TIME_WIDTH > ods_pkg::LEN_W) ? TIME_WIDTH : ods_pkg::LEN_W;

    // configuration
    logic [9:0]  r_near_thr;
    logic [7:0]  r_obs_width;
    logic [7:0]  r_clearance;
    logic [15:0] r_turn_ms;
    logic [15:0] r_ms_per_cm;
    logic [7:0]  r_drive_spd;
    logic [7:0]  r_turn_spd;

    // sequence state
    ods_pkg::t_phase               r_phase;
    logic [TIME_WIDTH-1:0]         r_start;
    logic [ods_pkg::LEN_W-1:0]     r_len;

    // result register
    logic                          r_out_valid;
    logic                          r_motor_write;
    ods_pkg::t_speed               r_left;
    ods_pkg::t_speed               r_right;
    ods_pkg::t_phase               r_phase_out;
    logic                          r_near;

    logic                          in_fire;
    logic [8:0]                    leg_sum;
    logic [ods_pkg::PROD_W-1:0]    leg_prod;
    logic [ods_pkg::LEN_W-1:0]     leg_ms;
    logic [ods_pkg::LEN_W-1:0]     turn_len;
    logic [TIME_WIDTH-1:0]         elapsed;
    logic                          done;
    ods_pkg::t_speed               spd_t;
    ods_pkg::t_speed               spd_d;
    ods_pkg::t_speed               spd_half;

    ods_pkg::t_phase               n_phase;
    logic [TIME_WIDTH-1:0]         n_start;
    logic [ods_pkg::LEN_W-1:0]     n_len;
    logic                          n_motor_write;
    ods_pkg::t_speed               n_left;
    ods_pkg::t_speed               n_right;
    logic                          n_near;

    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !r_out_valid || out_ch.ready;

    assign leg_sum  = {1'b0, r_obs_width} + {1'b0, r_clearance};
    assign leg_prod = ods_pkg::PROD_W'(leg_sum) * ods_pkg::PROD_W'(r_ms_per_cm);
    assign leg_ms   = leg_prod[ods_pkg::PROD_W-1:8];
    assign turn_len = ods_pkg::LEN_W'(r_turn_ms);

    // wrapping elapsed time
    assign elapsed = in_ch.now_ms - r_start;
    assign done    = CMP_W'(elapsed) >= CMP_W'(r_len);

    assign spd_t    = ods_pkg::t_speed'({1'b0, r_turn_spd});
    assign spd_d    = ods_pkg::t_speed'({1'b0, r_drive_spd});
    assign spd_half = ods_pkg::t_speed'({2'b00, r_drive_spd[7:1]});

    assign n_near = (in_ch.range_cm != '0) && (in_ch.range_cm <= r_near_thr);

    always_comb begin
        n_phase       = r_phase;
        n_start       = r_start;
        n_len         = r_len;
        n_motor_write = 1'b1;
        n_left        = '0;
        n_right       = '0;
        unique case (r_phase)
            ods_pkg::P_TURN_L1: begin
                n_left  = -spd_t;
                n_right = spd_t;
                if (done) begin
                    n_phase = ods_pkg::P_DRIVE_CLEAR;
                    n_start = in_ch.now_ms;
                    n_len   = leg_ms;
                end
            end
            ods_pkg::P_DRIVE_CLEAR: begin
                n_left  = spd_d;
                n_right = spd_d;
                if (done) begin
                    n_phase = ods_pkg::P_TURN_R1;
                    n_start = in_ch.now_ms;
                    n_len   = turn_len;
                end
            end
            ods_pkg::P_TURN_R1: begin
                n_left  = spd_t;
                n_right = -spd_t;
                if (done) begin
                    n_phase = ods_pkg::P_DRIVE_PASS;
                    n_start = in_ch.now_ms;
                    n_len   = leg_ms;
                end
            end
            ods_pkg::P_DRIVE_PASS: begin
                n_left  = spd_d;
                n_right = spd_d;
                if (done) begin
                    n_phase = ods_pkg::P_TURN_R2;
                    n_start = in_ch.now_ms;
                    n_len   = turn_len;
                end
            end
            ods_pkg::P_TURN_R2: begin
                n_left  = spd_t;
                n_right = -spd_t;
                if (done) begin
                    n_phase = ods_pkg::P_DRIVE_BACK;
                    n_start = in_ch.now_ms;
                    n_len   = leg_ms;
                end
            end
            ods_pkg::P_DRIVE_BACK: begin
                n_left  = spd_d;
                n_right = spd_d;
                if (done) begin
                    n_phase = ods_pkg::P_TURN_L2;
                    n_start = in_ch.now_ms;
                    n_len   = turn_len;
                end
            end
            ods_pkg::P_TURN_L2: begin
                n_left  = -spd_t;
                n_right = spd_t;
                if (done) begin
                    n_phase = ods_pkg::P_REACQUIRE;
                    n_start = in_ch.now_ms;
                    n_len   = '0;
                end
            end
            ods_pkg::P_REACQUIRE: begin
                // line found: stop command, back to idle
                if (in_ch.on_line) begin
                    n_phase = ods_pkg::P_IDLE;
                end else begin
                    n_left  = spd_half;
                    n_right = spd_half;
                end
            end
            default: begin
                // idle, and any unused code, starts the first turn silently
                n_motor_write = 1'b0;
                n_phase       = ods_pkg::P_TURN_L1;
                n_start       = in_ch.now_ms;
                n_len         = turn_len;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_thr  <= ods_pkg::RST_NEAR_THRESHOLD;
            r_obs_width <= ods_pkg::RST_OBSTACLE_WIDTH;
            r_clearance <= ods_pkg::RST_CLEARANCE;
            r_turn_ms   <= ods_pkg::RST_TURN_MS;
            r_ms_per_cm <= ods_pkg::RST_MS_PER_CM_Q8;
            r_drive_spd <= ods_pkg::RST_DRIVE_SPEED;
            r_turn_spd  <= ods_pkg::RST_TURN_SPEED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ods_pkg::REG_NEAR_THRESHOLD: r_near_thr  <= i_cfg_data[9:0];
                ods_pkg::REG_OBSTACLE_WIDTH: r_obs_width <= i_cfg_data[7:0];
                ods_pkg::REG_CLEARANCE:      r_clearance <= i_cfg_data[7:0];
                ods_pkg::REG_TURN_MS:        r_turn_ms   <= i_cfg_data;
                ods_pkg::REG_MS_PER_CM_Q8:   r_ms_per_cm <= i_cfg_data;
                ods_pkg::REG_DRIVE_SPEED:    r_drive_spd <= i_cfg_data[7:0];
                ods_pkg::REG_TURN_SPEED:     r_turn_spd  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ods_pkg::P_IDLE;
            r_start     <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase <= n_phase;
                r_start <= n_start;
                r_len   <= n_len;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_motor_write <= n_motor_write;
            r_left        <= n_left;
            r_right       <= n_right;
            r_phase_out   <= n_phase;
            r_near        <= n_near;
        end
    end

    assign out_ch.valid         = r_out_valid;
    assign out_ch.motor_write   = r_motor_write;
    assign out_ch.left_speed    = r_left;
    assign out_ch.right_speed   = r_right;
    assign out_ch.phase_now     = r_phase_out;
    assign out_ch.obstacle_near = r_near;

    `ODS_ASSERT_SAME(a_phase_legal, 1'b1, r_phase <= ods_pkg::P_REACQUIRE)
    `ODS_ASSERT_NEXT(a_idle_starts_turn, in_fire && (r_phase == ods_pkg::P_IDLE), (r_phase == ods_pkg::P_TURN_L1) && !out_ch.motor_write)
    `ODS_ASSERT_NEXT(a_line_stops, in_fire && (r_phase == ods_pkg::P_REACQUIRE) && in_ch.on_line, (r_phase == ods_pkg::P_IDLE) && (out_ch.left_speed == '0) && (out_ch.right_speed == '0))
    `ODS_ASSERT_NEXT(a_result_tracks_phase, in_fire, out_ch.valid && (out_ch.phase_now == r_phase))

endmodule
